// File: rtl/bdc_pkg.sv
package bdc_pkg;

    localparam int unsigned SEQ_W      = 32;
    localparam int unsigned CMD_W      = 32;
    localparam int unsigned FIELD_W    = 32;
    localparam int unsigned DELTA_W    = 33;
    localparam int unsigned ERR_W      = 34;
    localparam int unsigned CNT_W      = 32;
    localparam int unsigned GAIN_W     = 8;
    localparam int unsigned LIMIT_W    = 31;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd2;

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 8'd8;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd2000;
    localparam logic [SEQ_W-1:0]   END_RESET   = 32'd20000;

    // how the front classified an item
    typedef enum logic [1:0] {
        KIND_FIRST,
        KIND_COMPARE,
        KIND_IGNORED
    } kind_t;

    // one queue entry, front to back
    typedef struct packed {
        logic [SEQ_W-1:0]              seq;
        kind_t                         kind;
        logic [CNT_W-1:0]              items;
        logic                          finished;
        logic [2:0][CMD_W-1:0]         cmd;
        logic [2:0][DELTA_W-1:0]       delta;
    } entry_t;

    typedef struct packed {
        logic first_pending;
        logic done;
    } front_status_t;

endpackage

// File: rtl/bdc_front.sv
module bdc_front import bdc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [SEQ_W-1:0]      s_sequence_req,
    input  logic signed [CMD_W-1:0]   s_cmd_x,
    input  logic signed [CMD_W-1:0]   s_cmd_y,
    input  logic signed [CMD_W-1:0]   s_cmd_z,
    input  logic signed [FIELD_W-1:0] s_field_x,
    input  logic signed [FIELD_W-1:0] s_field_y,
    input  logic signed [FIELD_W-1:0] s_field_z,
    input  logic [SEQ_W-1:0]      end_sequence,
    input  logic                  q_full,
    output logic                  push,
    output entry_t                push_data,
    output front_status_t         status
);

    logic [2:0][FIELD_W-1:0] prev_reg, prev_next;
    logic [2:0][FIELD_W-1:0] field;
    logic                    first_reg, first_next;
    logic                    done_reg, done_next;
    logic [CNT_W-1:0]        items_reg, items_next;

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;
    assign field   = {s_field_z, s_field_y, s_field_x};

    assign status.first_pending = first_reg;
    assign status.done          = done_reg;

    always_comb begin
        prev_next  = prev_reg;
        first_next = first_reg;
        done_next  = done_reg;
        items_next = items_reg;

        push_data.seq = s_sequence_req;
        push_data.cmd = {s_cmd_z, s_cmd_y, s_cmd_x};
        for (int i = 0; i < 3; i++) begin
            push_data.delta[i] = {field[i][FIELD_W-1], field[i]}
                               - {prev_reg[i][FIELD_W-1], prev_reg[i]};
        end

        if (done_reg) begin
            push_data.kind = KIND_IGNORED;
        end else if (first_reg) begin
            push_data.kind = KIND_FIRST;
            first_next     = 1'b0;
            items_next     = items_reg + 1'b1;
            prev_next      = field;
        end else begin
            push_data.kind = KIND_COMPARE;
            items_next     = items_reg + 1'b1;
            prev_next      = field;
            if (s_sequence_req >= end_sequence) begin
                done_next = 1'b1;
            end
        end

        push_data.items    = items_next;
        push_data.finished = done_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= '0;
            first_reg <= 1'b1;
            done_reg  <= 1'b0;
            items_reg <= '0;
        end else if (push) begin
            prev_reg  <= prev_next;
            first_reg <= first_next;
            done_reg  <= done_next;
            items_reg <= items_next;
        end
    end

endmodule

// File: rtl/bdc_queue.sv
module bdc_queue import bdc_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_data,
    output logic   full,
    output logic   pop_valid,
    input  logic   pop_ready,
    output entry_t pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned FILL_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [FILL_W-1:0]  count_reg;
    logic               do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1)) r = '0;
        else                        r = p + 1'b1;
        return r;
    endfunction

    assign full      = (count_reg == FILL_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_pop    = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)   wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop) rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            case ({push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// File: rtl/bdc_back.sv
module bdc_back import bdc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [GAIN_W-1:0]    gain,
    input  logic [LIMIT_W-1:0]   command_limit,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  entry_t               q_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [SEQ_W-1:0]     m_sequence_out,
    output logic                 m_compared,
    output logic                 m_mismatch,
    output logic [ERR_W-1:0]     m_error_sum,
    output logic [CNT_W-1:0]     m_mismatch_total,
    output logic [ERR_W-1:0]     m_largest_error,
    output logic [CNT_W-1:0]     m_items_seen,
    output logic                 m_finished
);

    localparam int unsigned PROD_W = DELTA_W + GAIN_W;  // 41, magnitude < 2^40
    localparam int unsigned REF_W  = LIMIT_W + 1;
    localparam int unsigned ABS_W  = CMD_W;             // |cmd - ref| < 2^32

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        kind_t            kind;
        logic [CNT_W-1:0] items;
        logic             finished;
    } meta_t;

    typedef struct packed {
        meta_t                       meta;
        logic [2:0][CMD_W-1:0]       cmd;
        logic [2:0][PROD_W-1:0]      prod;
    } st1_t;

    typedef struct packed {
        meta_t                       meta;
        logic [2:0][CMD_W-1:0]       cmd;
        logic [2:0][REF_W-1:0]       refc;
    } st2_t;

    typedef struct packed {
        meta_t                       meta;
        logic [2:0][ABS_W-1:0]       mag;
    } st3_t;

    typedef struct packed {
        meta_t            meta;
        logic [ERR_W-1:0] err;
    } st4_t;

    st1_t st1_reg, st1_next;
    st2_t st2_reg, st2_next;
    st3_t st3_reg, st3_next;
    st4_t st4_reg, st4_next;
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic take1, take2, take3, take4, take_out;

    logic [SEQ_W-1:0] seq_out_reg;
    logic             compared_reg;
    logic             mismatch_reg;
    logic [ERR_W-1:0] err_out_reg;
    logic [CNT_W-1:0] mismatch_cnt_reg;
    logic [ERR_W-1:0] peak_reg;
    logic [CNT_W-1:0] items_out_reg;
    logic             finished_reg;
    logic             out_compared;
    logic             out_mismatch;

    logic signed [PROD_W:0]   prod_full [3];
    logic signed [PROD_W-1:0] lim_w;
    logic signed [PROD_W-1:0] neg_lim_w;
    logic signed [PROD_W-1:0] neg_prod [3];
    logic signed [CMD_W:0]    diff_a [3];
    logic signed [CMD_W:0]    diff_b [3];

    // per-stage load enables, back to front
    assign take_out = !out_valid_reg || m_ready;
    assign take4    = !v4_reg || take_out;
    assign take3    = !v3_reg || take4;
    assign take2    = !v2_reg || take3;
    assign take1    = !v1_reg || take2;
    assign q_ready  = take1;

    // stage 1: field change times gain
    always_comb begin
        st1_next.meta = '{seq: q_data.seq, kind: q_data.kind,
                          items: q_data.items, finished: q_data.finished};
        st1_next.cmd  = q_data.cmd;
        for (int i = 0; i < 3; i++) begin
            prod_full[i]     = $signed(q_data.delta[i]) * $signed({1'b0, gain});
            st1_next.prod[i] = prod_full[i][PROD_W-1:0];
        end
    end

    // stage 2: ref = -prod, clamped to +/- limit
    assign lim_w     = $signed({{(PROD_W-LIMIT_W){1'b0}}, command_limit});
    assign neg_lim_w = -lim_w;

    always_comb begin
        st2_next.meta = st1_reg.meta;
        st2_next.cmd  = st1_reg.cmd;
        for (int i = 0; i < 3; i++) begin
            neg_prod[i] = -$signed(st1_reg.prod[i]);
            if ($signed(st1_reg.prod[i]) < neg_lim_w) begin
                st2_next.refc[i] = {1'b0, command_limit};
            end else if ($signed(st1_reg.prod[i]) > lim_w) begin
                st2_next.refc[i] = -{1'b0, command_limit};
            end else begin
                st2_next.refc[i] = neg_prod[i][REF_W-1:0];
            end
        end
    end

    // stage 3: absolute difference, both signs in parallel
    always_comb begin
        st3_next.meta = st2_reg.meta;
        for (int i = 0; i < 3; i++) begin
            diff_a[i] = $signed({st2_reg.cmd[i][CMD_W-1], st2_reg.cmd[i]})
                      - $signed({st2_reg.refc[i][REF_W-1], st2_reg.refc[i]});
            diff_b[i] = $signed({st2_reg.refc[i][REF_W-1], st2_reg.refc[i]})
                      - $signed({st2_reg.cmd[i][CMD_W-1], st2_reg.cmd[i]});
            st3_next.mag[i] = diff_a[i][CMD_W] ? diff_b[i][ABS_W-1:0]
                                               : diff_a[i][ABS_W-1:0];
        end
    end

    // stage 4: three-axis sum, zero unless compared
    always_comb begin
        st4_next.meta = st3_reg.meta;
        if (st3_reg.meta.kind == KIND_COMPARE) begin
            st4_next.err = ERR_W'(st3_reg.mag[0]) + ERR_W'(st3_reg.mag[1])
                         + ERR_W'(st3_reg.mag[2]);
        end else begin
            st4_next.err = '0;
        end
    end

    assign out_compared = (st4_reg.meta.kind == KIND_COMPARE);
    assign out_mismatch = out_compared && (st4_reg.err != '0);

    always_ff @(posedge aclk) begin
        if (take1) st1_reg <= st1_next;
        if (take2) st2_reg <= st2_next;
        if (take3) st3_reg <= st3_next;
        if (take4) st4_reg <= st4_next;
        if (take_out && v4_reg) begin
            seq_out_reg   <= st4_reg.meta.seq;
            compared_reg  <= out_compared;
            mismatch_reg  <= out_mismatch;
            err_out_reg   <= st4_reg.err;
            items_out_reg <= st4_reg.meta.items;
            finished_reg  <= st4_reg.meta.finished;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            v4_reg           <= 1'b0;
            out_valid_reg    <= 1'b0;
            mismatch_cnt_reg <= '0;
            peak_reg         <= '0;
        end else begin
            if (take1)    v1_reg        <= q_valid;
            if (take2)    v2_reg        <= v1_reg;
            if (take3)    v3_reg        <= v2_reg;
            if (take4)    v4_reg        <= v3_reg;
            if (take_out) out_valid_reg <= v4_reg;
            if (take_out && v4_reg && out_mismatch) begin
                mismatch_cnt_reg <= mismatch_cnt_reg + 1'b1;
                if (st4_reg.err > peak_reg) begin
                    peak_reg <= st4_reg.err;
                end
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_sequence_out   = seq_out_reg;
    assign m_compared       = compared_reg;
    assign m_mismatch       = mismatch_reg;
    assign m_error_sum      = err_out_reg;
    assign m_mismatch_total = mismatch_cnt_reg;
    assign m_largest_error  = peak_reg;
    assign m_items_seen     = items_out_reg;
    assign m_finished       = finished_reg;

endmodule

// File: rtl/bdot_command_checker_top.sv
// B-dot command checker. Each input transfer carries one three-axis field
// sample and the coil command issued for it; each one yields exactly one
// result transfer, in order. The reference command per axis is
// -gain * (field - previous field), clamped to +/- command_limit, and the
// result reports the sum of absolute differences to the issued command plus
// running counters (items, mismatches, largest error). The first item only
// stores its sample; once a compared item carries a sequence number at or
// above end_sequence the run is finished and later items are passed through
// with counters frozen. Throughput is one item per clock while the queue is
// not full and m_ready does not hold a result: the front keeps the previous
// sample and the run state and classifies each item in its acceptance cycle,
// and every stage of the back (multiply, clamp, absolute difference, sum,
// accumulate) takes a new item each cycle unless held by m_ready. A queue of
// QUEUE_DEPTH entries sits between front and back, so input transfers keep
// being taken while a result waits on m_ready until the queue fills. There is
// no clearing pass after reset. Configuration (index 0 gain, 1 command_limit,
// 2 end_sequence; other indexes ignored, data masked to register width) is
// taken every cycle and should only change while no item is in flight.
module bdot_command_checker_top import bdc_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    // configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,

    // input items
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [SEQ_W-1:0]          s_sequence_req,
    input  logic signed [CMD_W-1:0]   s_cmd_x,
    input  logic signed [CMD_W-1:0]   s_cmd_y,
    input  logic signed [CMD_W-1:0]   s_cmd_z,
    input  logic signed [FIELD_W-1:0] s_field_x,
    input  logic signed [FIELD_W-1:0] s_field_y,
    input  logic signed [FIELD_W-1:0] s_field_z,

    // results
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [SEQ_W-1:0]          m_sequence_out,
    output logic                      m_compared,
    output logic                      m_mismatch,
    output logic [ERR_W-1:0]          m_error_sum,
    output logic [CNT_W-1:0]          m_mismatch_total,
    output logic [ERR_W-1:0]          m_largest_error,
    output logic [CNT_W-1:0]          m_items_seen,
    output logic                      m_finished
);

    logic [GAIN_W-1:0]  gain_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [SEQ_W-1:0]   end_seq_reg;

    logic               q_full;
    logic               q_push;
    entry_t             q_push_data;
    logic               q_valid;
    logic               q_ready;
    entry_t             q_data;
    front_status_t      fr_status;

    // config writes never stall
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg    <= GAIN_RESET;
            limit_reg   <= LIMIT_RESET;
            end_seq_reg <= END_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_GAIN:  gain_reg    <= cfg_data[GAIN_W-1:0];
                CFG_LIMIT: limit_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_END:   end_seq_reg <= cfg_data[SEQ_W-1:0];
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    // front: run state, previous sample, classification
    bdc_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sequence_req (s_sequence_req),
        .s_cmd_x        (s_cmd_x),
        .s_cmd_y        (s_cmd_y),
        .s_cmd_z        (s_cmd_z),
        .s_field_x      (s_field_x),
        .s_field_y      (s_field_y),
        .s_field_z      (s_field_z),
        .end_sequence   (end_seq_reg),
        .q_full         (q_full),
        .push           (q_push),
        .push_data      (q_push_data),
        .status         (fr_status)
    );

    // decoupling queue
    bdc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_data  (q_data)
    );

    // back: reference command, error sum, accumulators, output register
    bdc_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .gain             (gain_reg),
        .command_limit    (limit_reg),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_data           (q_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sequence_out   (m_sequence_out),
        .m_compared       (m_compared),
        .m_mismatch       (m_mismatch),
        .m_error_sum      (m_error_sum),
        .m_mismatch_total (m_mismatch_total),
        .m_largest_error  (m_largest_error),
        .m_items_seen     (m_items_seen),
        .m_finished       (m_finished)
    );

    // a mismatch only comes from a compare with a nonzero sum
    a_mismatch_needs_compare: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_mismatch |-> m_compared && (m_error_sum != '0))
        else $error("mismatch flagged without a nonzero compared error");

    // peak tracking covers the reported error
    a_peak_covers_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_compared |-> m_largest_error >= m_error_sum)
        else $error("largest error below current error sum");

    // run end is sticky
    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(fr_status.done))
        else $error("done flag cleared without reset");

    // run can only end after the first sample was stored
    a_done_after_first: assert property (@(posedge aclk) disable iff (!aresetn)
        fr_status.done |-> !fr_status.first_pending)
        else $error("done set while first sample still pending");

endmodule
